// ===== hdl/tlc_pkg.sv =====
// Shared constants and types of the two-way LRU cache tag lookup.
package tlc_pkg;

  localparam int unsigned SetCount  = 64;
  localparam int unsigned LineBytes = 32;
  localparam int unsigned AddrW     = 32;
  localparam int unsigned OffW      = $clog2(LineBytes);
  localparam int unsigned SetW      = $clog2(SetCount);
  localparam int unsigned BlockW    = AddrW - OffW;
  localparam int unsigned TagW      = AddrW - OffW - SetW;
  localparam int unsigned RowW      = 2 * TagW;
  localparam int unsigned CountW    = 32;

  typedef enum logic [0:0] {
    StIdle,
    StLookup
  } state_e;

  typedef struct packed {
    logic access;
    logic miss;
  } stat_evt_t;

  typedef struct packed {
    logic [CountW-1:0] access_count;
    logic [CountW-1:0] miss_count;
  } stat_cnt_t;

endpackage

// ===== hdl/tlc_intf.sv =====
// Request and response channel interfaces of the cache tag lookup.
interface tlc_req_if;
  logic                      valid;
  logic                      ready;
  logic [tlc_pkg::AddrW-1:0] address;

  modport source (output valid, output address, input ready);
  modport sink   (input valid, input address, output ready);
endinterface

interface tlc_rsp_if;
  logic                       valid;
  logic                       ready;
  logic [tlc_pkg::OffW-1:0]   byte_offset;
  logic [tlc_pkg::BlockW-1:0] block_number;
  logic [tlc_pkg::SetW-1:0]   set_index;
  logic                       way;
  logic [tlc_pkg::TagW-1:0]   tag;
  logic                       miss;
  logic                       replacement;
  logic [tlc_pkg::TagW-1:0]   evicted_tag;
  logic [tlc_pkg::CountW-1:0] access_count;
  logic [tlc_pkg::CountW-1:0] miss_count;

  modport source (output valid, output byte_offset, output block_number, output set_index,
                  output way, output tag, output miss, output replacement,
                  output evicted_tag, output access_count, output miss_count,
                  input ready);
  modport sink   (input valid, input byte_offset, input block_number, input set_index,
                  input way, input tag, input miss, input replacement,
                  input evicted_tag, input access_count, input miss_count,
                  output ready);
endinterface

// ===== hdl/tlc_tag_ram.sv =====
// Single-port synchronous RAM with registered read data.
module tlc_tag_ram #(
  parameter int unsigned Depth = 64,
  parameter int unsigned Width = 42
) (
  input  logic                     clk_i,
  input  logic                     re_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/tlc_stats.sv =====
// Saturating access and miss counters.
module tlc_stats (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tlc_pkg::stat_evt_t evt_i,
  output tlc_pkg::stat_cnt_t cnt_next_o
);

  logic [tlc_pkg::CountW-1:0] access_q, access_d;
  logic [tlc_pkg::CountW-1:0] miss_q, miss_d;

  always_comb begin
    access_d = access_q;
    miss_d   = miss_q;
    if (evt_i.access && (access_q != '1)) begin
      access_d = access_q + 1'b1;
    end
    if (evt_i.miss && (miss_q != '1)) begin
      miss_d = miss_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      access_q <= '0;
      miss_q   <= '0;
    end else begin
      access_q <= access_d;
      miss_q   <= miss_d;
    end
  end

  assign cnt_next_o.access_count = access_d;
  assign cnt_next_o.miss_count   = miss_d;

endmodule

// ===== hdl/two_way_lru_cache_tag_lookup.sv =====
// Top level of the two-way set-associative cache tag lookup with one LRU bit per set.
// For each address item, the set's row of both stored tags is read from a synchronous
// tag RAM in the cycle the item is accepted; in the lookup state that follows, once the
// output register can take it, both ways are compared, the victim row is written back on a
// miss and the result is loaded into the output register. A new item is accepted while
// a finished result still waits there; the lookup waits only while that register is full.
// Reset clears the valid flip-flops and sets the LRU ones, so no clearing pass is needed.
module two_way_lru_cache_tag_lookup (
  input  logic            clk_i,
  input  logic            rst_ni,
  tlc_req_if.sink         req_i,
  tlc_rsp_if.source       rsp_o
);

  tlc_pkg::state_e state_q, state_d;

  logic [tlc_pkg::AddrW-1:0]    addr_q;
  logic [tlc_pkg::SetCount-1:0] valid0_q, valid1_q, lru_q;

  logic                       ram_re, ram_we;
  logic [tlc_pkg::SetW-1:0]   ram_addr;
  logic [tlc_pkg::RowW-1:0]   ram_wdata, ram_rdata;

  logic                       slot_free, lookup_fire;
  logic [tlc_pkg::SetW-1:0]   set_l;
  logic [tlc_pkg::TagW-1:0]   tag_l, tag0, tag1, victim_tag;
  logic                       hit0, hit1, miss, way, victim_valid, repl;

  tlc_pkg::stat_evt_t stat_evt;
  tlc_pkg::stat_cnt_t stat_next;

  logic                       rsp_valid_q;
  logic [tlc_pkg::OffW-1:0]   off_q;
  logic [tlc_pkg::BlockW-1:0] block_q;
  logic [tlc_pkg::SetW-1:0]   set_q;
  logic                       way_q, miss_q, repl_q;
  logic [tlc_pkg::TagW-1:0]   tag_q, evicted_q;
  logic [tlc_pkg::CountW-1:0] access_cnt_q, miss_cnt_q;

  assign slot_free = !rsp_valid_q || rsp_o.ready;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tlc_pkg::StIdle: begin
        if (req_i.valid) begin
          state_d = tlc_pkg::StLookup;
        end
      end
      tlc_pkg::StLookup: begin
        if (slot_free) begin
          state_d = tlc_pkg::StIdle;
        end
      end
      default: state_d = tlc_pkg::StIdle;
    endcase
  end

  always_comb begin
    req_i.ready = 1'b0;
    lookup_fire = 1'b0;
    unique case (state_q)
      tlc_pkg::StIdle:   req_i.ready = 1'b1;
      tlc_pkg::StLookup: lookup_fire = slot_free;
      default: begin
        req_i.ready = 1'b0;
        lookup_fire = 1'b0;
      end
    endcase
  end

  assign set_l = addr_q[tlc_pkg::OffW +: tlc_pkg::SetW];
  assign tag_l = addr_q[tlc_pkg::AddrW-1 -: tlc_pkg::TagW];
  assign tag0  = ram_rdata[tlc_pkg::TagW-1:0];
  assign tag1  = ram_rdata[tlc_pkg::RowW-1 -: tlc_pkg::TagW];

  assign hit0         = valid0_q[set_l] && (tag0 == tag_l);
  assign hit1         = !hit0 && valid1_q[set_l] && (tag1 == tag_l);
  assign miss         = !hit0 && !hit1;
  assign way          = hit0 ? 1'b0 : (hit1 ? 1'b1 : !lru_q[set_l]);
  assign victim_valid = way ? valid1_q[set_l] : valid0_q[set_l];
  assign victim_tag   = way ? tag1 : tag0;
  assign repl         = miss && victim_valid;

  assign ram_re    = req_i.valid && req_i.ready;
  assign ram_we    = lookup_fire && miss;
  assign ram_addr  = ram_re ? req_i.address[tlc_pkg::OffW +: tlc_pkg::SetW] : set_l;
  assign ram_wdata = way ? {tag_l, tag0} : {tag1, tag_l};

  tlc_tag_ram #(
    .Depth(tlc_pkg::SetCount),
    .Width(tlc_pkg::RowW)
  ) u_tag_ram (
    .clk_i  (clk_i),
    .re_i   (ram_re),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(ram_wdata),
    .rdata_o(ram_rdata)
  );

  assign stat_evt.access = lookup_fire;
  assign stat_evt.miss   = lookup_fire && miss;

  tlc_stats u_stats (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .evt_i     (stat_evt),
    .cnt_next_o(stat_next)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tlc_pkg::StIdle;
      valid0_q    <= '0;
      valid1_q    <= '0;
      lru_q       <= '1;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (lookup_fire) begin
        lru_q[set_l] <= way;
        if (miss && !way) begin
          valid0_q[set_l] <= 1'b1;
        end
        if (miss && way) begin
          valid1_q[set_l] <= 1'b1;
        end
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ram_re) begin
      addr_q <= req_i.address;
    end
    if (lookup_fire) begin
      off_q        <= addr_q[tlc_pkg::OffW-1:0];
      block_q      <= addr_q[tlc_pkg::AddrW-1 -: tlc_pkg::BlockW];
      set_q        <= set_l;
      way_q        <= way;
      tag_q        <= tag_l;
      miss_q       <= miss;
      repl_q       <= repl;
      evicted_q    <= repl ? victim_tag : '0;
      access_cnt_q <= stat_next.access_count;
      miss_cnt_q   <= stat_next.miss_count;
    end
  end

  assign rsp_o.valid        = rsp_valid_q;
  assign rsp_o.byte_offset  = off_q;
  assign rsp_o.block_number = block_q;
  assign rsp_o.set_index    = set_q;
  assign rsp_o.way          = way_q;
  assign rsp_o.tag          = tag_q;
  assign rsp_o.miss         = miss_q;
  assign rsp_o.replacement  = repl_q;
  assign rsp_o.evicted_tag  = evicted_q;
  assign rsp_o.access_count = access_cnt_q;
  assign rsp_o.miss_count   = miss_cnt_q;

endmodule
